/* rtl/core/u8dv_pkg.sv */
package u8dv_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_LEN2     = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3     = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4     = 21'h010000;

    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_OVERLONG  = 3'd3,
        ST_SURROGATE = 3'd4,
        ST_RANGE     = 3'd5,
        ST_TRUNC     = 3'd6
    } u8dv_status_t;

    typedef struct packed {
        logic [1:0]       remaining;
        logic [LEN_W-1:0] seq_len;
        logic [CP_W-1:0]  acc;
        logic             buffer_ok;
    } u8dv_state_t;

    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        u8dv_status_t     status;
        logic [LEN_W-1:0] seq_length;
        logic             stream_valid;
        logic             last;
    } u8dv_result_t;

endpackage

/* rtl/core/u8dv_step.sv */
module u8dv_step import u8dv_pkg::*; (
    input  u8dv_state_t       state_cur,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_buffer,
    output u8dv_state_t       state_nxt,
    output logic              res_valid,
    output u8dv_result_t      res
);

    always_comb begin
        logic [CP_W-1:0]  acc_shift;
        logic [LEN_W-1:0] len_inc;
        u8dv_status_t     st;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             emit;
        logic             go_idle;

        acc_shift = {state_cur.acc[CP_W-7:0], in_byte[5:0]};
        len_inc   = state_cur.seq_len + LEN_ONE;
        st        = ST_OK;
        cp        = '0;
        len       = LEN_ONE;
        emit      = 1'b0;
        go_idle   = 1'b0;
        state_nxt = state_cur;

        if (state_cur.remaining == 2'd0) begin
            if (!in_byte[7]) begin
                emit    = 1'b1;
                go_idle = 1'b1;
                cp      = {{(CP_W-BYTE_W){1'b0}}, in_byte};
            end else if (in_byte[7:1] == 7'b1100000) begin
                emit    = 1'b1;
                go_idle = 1'b1;
                st      = ST_OVERLONG;
            end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
                         in_byte[7:3] == 5'b11110) begin
                state_nxt.seq_len = LEN_ONE;
                if (in_byte[7:5] == 3'b110) begin
                    state_nxt.remaining = 2'd1;
                    state_nxt.acc       = {{(CP_W-5){1'b0}}, in_byte[4:0]};
                end else if (in_byte[7:4] == 4'b1110) begin
                    state_nxt.remaining = 2'd2;
                    state_nxt.acc       = {{(CP_W-4){1'b0}}, in_byte[3:0]};
                end else begin
                    state_nxt.remaining = 2'd3;
                    state_nxt.acc       = {{(CP_W-3){1'b0}}, in_byte[2:0]};
                end
                if (end_of_buffer) begin
                    emit    = 1'b1;
                    go_idle = 1'b1;
                    st      = ST_TRUNC;
                end
            end else begin
                emit    = 1'b1;
                go_idle = 1'b1;
                st      = ST_BAD_LEAD;
            end
        end else if (in_byte[7:6] != 2'b10) begin
            emit    = 1'b1;
            go_idle = 1'b1;
            st      = ST_BAD_CONT;
            len     = len_inc;
        end else begin
            state_nxt.acc       = acc_shift;
            state_nxt.seq_len   = len_inc;
            state_nxt.remaining = state_cur.remaining - 2'd1;
            len                 = len_inc;
            if (state_cur.remaining == 2'd1) begin
                emit    = 1'b1;
                go_idle = 1'b1;
                cp      = acc_shift;
                if ((len_inc == LEN_TWO && acc_shift < MIN_LEN2) ||
                    (len_inc == LEN_THREE && acc_shift < MIN_LEN3) ||
                    (len_inc == LEN_FOUR && acc_shift < MIN_LEN4)) begin
                    st = ST_OVERLONG;
                end else if (acc_shift > CP_MAX) begin
                    st = ST_RANGE;
                end else if (acc_shift >= SURR_LO && acc_shift <= SURR_HI) begin
                    st = ST_SURROGATE;
                end
            end else if (end_of_buffer) begin
                emit    = 1'b1;
                go_idle = 1'b1;
                st      = ST_TRUNC;
            end
        end

        if (go_idle) begin
            state_nxt.remaining = 2'd0;
            state_nxt.seq_len   = '0;
            state_nxt.acc       = '0;
        end

        res.codepoint    = (st == ST_OK) ? cp : '0;
        res.status       = st;
        res.seq_length   = len;
        res.stream_valid = state_cur.buffer_ok & (st == ST_OK);
        res.last         = end_of_buffer;
        res_valid        = emit;

        if (emit) begin
            state_nxt.buffer_ok = end_of_buffer ? 1'b1 : res.stream_valid;
        end
    end

endmodule

/* rtl/core/utf8_stream_decoder_validator.sv */
// UTF-8 stream decoder and validator. One byte is taken per cycle on the s_ side, with
// s_tlast marking the last byte of a buffer; every byte that completes or breaks a
// sequence, and every last byte, yields one beat on the m_ side in the next cycle, from a
// single result register. Lead bytes that open a sequence yield no beat. s_tready is high
// whenever the result register is empty or being drained, so the block runs at one byte
// per clock as long as the sink keeps m_tready high; the sink's m_tready sets the rate.
module utf8_stream_decoder_validator import u8dv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [20:0] codepoint, [23:21] seq_length, [24] stream_valid
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // last
);

    u8dv_state_t  state_reg;
    u8dv_state_t  state_next;
    u8dv_result_t res_reg;
    u8dv_result_t res_next;
    logic         m_tvalid_reg;
    logic         res_valid;
    logic         s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    u8dv_step u_step (
        .state_cur     (state_reg),
        .in_byte       (s_tdata),
        .end_of_buffer (s_tlast),
        .state_nxt     (state_next),
        .res_valid     (res_valid),
        .res           (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.remaining <= 2'd0;
            state_reg.seq_len   <= '0;
            state_reg.acc       <= '0;
            state_reg.buffer_ok <= 1'b1;
            m_tvalid_reg        <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                m_tvalid_reg <= res_valid;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, res_reg.stream_valid, res_reg.seq_length, res_reg.codepoint};
    assign m_tuser  = res_reg.status;
    assign m_tlast  = res_reg.last;

endmodule

/* rtl/core/u8dv_checker.sv */
module u8dv_checker import u8dv_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[20:0] == 21'd0 && !m_tdata[24])
        else $error("error beat carries codepoint or valid flag");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:21] != 3'd0 && m_tdata[23:21] <= LEN_FOUR)
        else $error("sequence length out of range");

    a_ascii_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tdata[7] && $past(!m_tvalid || m_tready) |=> m_tvalid)
        else $error("single byte gave no result beat");

endmodule

bind utf8_stream_decoder_validator u8dv_checker u_u8dv_checker (.*);
